// ===== rtl/fsp_pkg.sv =====
package fsp_pkg;

    // Input operation codes
    localparam logic [2:0] OP_FMT_BYTE = 3'd0;
    localparam logic [2:0] OP_INT_ARG  = 3'd1;
    localparam logic [2:0] OP_STR_BYTE = 3'd2;
    localparam logic [2:0] OP_STR_END  = 3'd3;
    localparam logic [2:0] OP_NULL_STR = 3'd4;
    localparam logic [2:0] OP_FMT_END  = 3'd5;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 31;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Character stack: a sign and ten digits fit with room to spare
    localparam int STACK_DEPTH = 12;
    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
    localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);

    // Divide by ten through the reciprocal: q = (v * RECIP_10) >> RECIP_SHIFT
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_S       = 8'h73;
    localparam logic [BYTE_W-1:0] CH_D       = 8'h64;
    localparam logic [BYTE_W-1:0] CH_X       = 8'h78;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;

    localparam int                NULL_LEN   = 6;
    localparam int                NULL_IDX_W = $clog2(NULL_LEN);

    typedef enum logic [1:0] {
        AW_NONE,
        AW_STR,
        AW_DEC,
        AW_HEX
    } t_await;

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] digit);
        logic [BYTE_W-1:0] ch;
        case (digit)
            4'd0:    ch = 8'h30;
            4'd1:    ch = 8'h31;
            4'd2:    ch = 8'h32;
            4'd3:    ch = 8'h33;
            4'd4:    ch = 8'h34;
            4'd5:    ch = 8'h35;
            4'd6:    ch = 8'h36;
            4'd7:    ch = 8'h37;
            4'd8:    ch = 8'h38;
            4'd9:    ch = 8'h39;
            4'd10:   ch = 8'h61;
            4'd11:   ch = 8'h62;
            4'd12:   ch = 8'h63;
            4'd13:   ch = 8'h64;
            4'd14:   ch = 8'h65;
            default: ch = 8'h66;
        endcase
        return ch;
    endfunction

    // "(null)" by position
    function automatic logic [BYTE_W-1:0] null_char(input logic [NULL_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h28;
            3'd1:    ch = 8'h6E;
            3'd2:    ch = 8'h75;
            3'd3:    ch = 8'h6C;
            3'd4:    ch = 8'h6C;
            default: ch = 8'h29;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/fsp_in_if.sv =====
interface fsp_in_if;
    logic                          valid;
    logic                          ready;
    logic [fsp_pkg::OP_W-1:0]      operation;
    logic [fsp_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

// ===== rtl/fsp_out_if.sv =====
interface fsp_out_if;
    logic                          valid;
    logic                          ready;
    logic [fsp_pkg::BYTE_W-1:0]    out_byte;
    logic                          is_last;
    logic [fsp_pkg::COUNT_W-1:0]   char_count;
    logic                          done_res;

    modport source (output valid, output out_byte, output is_last, output char_count,
                    output done_res, input ready);
    modport sink   (input valid, input out_byte, input is_last, input char_count,
                    input done_res, output ready);
endinterface

// ===== rtl/format_string_printer.sv =====
// Streaming printf-style formatter for %s, %d, %x and %%. Format bytes, integer
// arguments and string bytes arrive as input beats; every emitted character leaves
// as one output beat with the running character count (saturating at 2^31-1), and
// format end adds a completion beat (done_res=1, out_byte=0) with the total. The
// input side is ready only while the sequencer is idle. An item is accepted, then
// the characters it builds are stacked, then each is delivered while the sink is
// ready. Characters are built on a 12-entry stack: integer arguments go through a
// single shared divide-by-radix unit (a reciprocal multiply for base ten, a shift
// for base sixteen) producing one digit per cycle, least significant first, and the
// sign is pushed last so that popping gives the printed order. Items that cause no
// output leave the sequencer idle.
module format_string_printer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsp_in_if.sink    i_in,
    fsp_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_NULL,
        S_OUT
    } t_state;

    t_state                                r_state;
    logic                                  r_pending;
    fsp_pkg::t_await                       r_await;
    logic [fsp_pkg::COUNT_W-1:0]           r_cnt;
    logic                                  r_fin;

    // Character stack, popped from the top
    logic [fsp_pkg::BYTE_W-1:0]            r_stk [fsp_pkg::STACK_DEPTH];
    logic [fsp_pkg::STACK_CNT_W-1:0]       r_sp;

    // Digit sequencer
    logic [fsp_pkg::VALUE_W-1:0]           r_mag;
    logic                                  r_dec;
    logic                                  r_neg;
    logic [fsp_pkg::NULL_IDX_W-1:0]        r_ni;

    // Output register
    logic                                  r_ov;
    logic [fsp_pkg::BYTE_W-1:0]            r_byte;
    logic                                  r_last;
    logic [fsp_pkg::COUNT_W-1:0]           r_ocnt;
    logic                                  r_done;

    logic [fsp_pkg::VALUE_W-1:0]           w_quot;
    logic [3:0]                            w_digit;
    logic [fsp_pkg::BYTE_W-1:0]            w_b;
    logic [fsp_pkg::STACK_CNT_W-1:0]       w_top;
    logic [fsp_pkg::COUNT_W-1:0]           w_cnt_inc;
    logic                                  w_take;
    logic                                  w_load_ok;

    fsp_digit u_digit (
        .i_mag   (r_mag),
        .i_dec   (r_dec),
        .o_quot  (w_quot),
        .o_digit (w_digit)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_byte;
    assign o_out.is_last    = r_last;
    assign o_out.char_count = r_ocnt;
    assign o_out.done_res   = r_done;

    assign w_take    = i_in.valid && (r_state == S_IDLE);
    assign w_b       = i_in.value[fsp_pkg::BYTE_W-1:0];
    assign w_top     = r_sp - fsp_pkg::STACK_CNT_W'(1);
    assign w_cnt_inc = (r_cnt == fsp_pkg::COUNT_MAX) ? r_cnt
                                                     : r_cnt + fsp_pkg::COUNT_W'(1);
    assign w_load_ok = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= 1'b0;
            r_await   <= fsp_pkg::AW_NONE;
            r_cnt     <= '0;
            r_fin     <= 1'b0;
            r_sp      <= '0;
            r_ov      <= 1'b0;
        end else begin
            // Drop the beat once the sink takes it; S_OUT reloads it itself
            if (r_ov && o_out.ready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        case (i_in.operation)
                            fsp_pkg::OP_FMT_BYTE: begin
                                // Any awaited conversion is dropped by a format byte
                                if (r_pending) begin
                                    r_pending <= 1'b0;
                                    if (w_b == fsp_pkg::CH_S) begin
                                        r_await <= fsp_pkg::AW_STR;
                                    end else if (w_b == fsp_pkg::CH_D) begin
                                        r_await <= fsp_pkg::AW_DEC;
                                    end else if (w_b == fsp_pkg::CH_X) begin
                                        r_await <= fsp_pkg::AW_HEX;
                                    end else begin
                                        r_await <= fsp_pkg::AW_NONE;
                                        if (w_b == fsp_pkg::CH_PERCENT) begin
                                            r_stk[0] <= fsp_pkg::CH_PERCENT;
                                            r_sp     <= fsp_pkg::STACK_CNT_W'(1);
                                            r_state  <= S_OUT;
                                        end
                                        // unknown specifier: swallow both bytes
                                    end
                                end else begin
                                    r_await <= fsp_pkg::AW_NONE;
                                    if (w_b == fsp_pkg::CH_PERCENT) begin
                                        r_pending <= 1'b1;
                                    end else begin
                                        r_stk[0] <= w_b;
                                        r_sp     <= fsp_pkg::STACK_CNT_W'(1);
                                        r_state  <= S_OUT;
                                    end
                                end
                            end
                            fsp_pkg::OP_INT_ARG: begin
                                if (r_await == fsp_pkg::AW_DEC || r_await == fsp_pkg::AW_HEX) begin
                                    r_await <= fsp_pkg::AW_NONE;
                                    r_dec   <= (r_await == fsp_pkg::AW_DEC);
                                    // Two's-complement negate; the most negative value
                                    // maps onto its own unsigned magnitude
                                    if (r_await == fsp_pkg::AW_DEC
                                        && i_in.value[fsp_pkg::VALUE_W-1]) begin
                                        r_neg <= 1'b1;
                                        r_mag <= ~i_in.value + fsp_pkg::VALUE_W'(1);
                                    end else begin
                                        r_neg <= 1'b0;
                                        r_mag <= i_in.value;
                                    end
                                    r_state <= S_DIV;
                                end
                            end
                            fsp_pkg::OP_STR_BYTE: begin
                                if (r_await == fsp_pkg::AW_STR) begin
                                    r_stk[0] <= w_b;
                                    r_sp     <= fsp_pkg::STACK_CNT_W'(1);
                                    r_state  <= S_OUT;
                                end
                            end
                            fsp_pkg::OP_STR_END: begin
                                if (r_await == fsp_pkg::AW_STR) begin
                                    r_await <= fsp_pkg::AW_NONE;
                                end
                            end
                            fsp_pkg::OP_NULL_STR: begin
                                if (r_await == fsp_pkg::AW_STR) begin
                                    r_await <= fsp_pkg::AW_NONE;
                                    r_ni    <= fsp_pkg::NULL_IDX_W'(fsp_pkg::NULL_LEN - 1);
                                    r_state <= S_NULL;
                                end
                            end
                            fsp_pkg::OP_FMT_END: begin
                                // Print a trailing lone percent, then the completion beat
                                if (r_pending) begin
                                    r_stk[0] <= fsp_pkg::CH_PERCENT;
                                    r_sp     <= fsp_pkg::STACK_CNT_W'(1);
                                end
                                r_pending <= 1'b0;
                                r_await   <= fsp_pkg::AW_NONE;
                                r_fin     <= 1'b1;
                                r_state   <= S_OUT;
                            end
                            default: begin
                                // unused codes: ignore
                            end
                        endcase
                    end
                end

                S_DIV: begin
                    // Push one digit per cycle, least significant first
                    r_stk[r_sp[fsp_pkg::STACK_IDX_W-1:0]] <= fsp_pkg::hex_char(w_digit);
                    r_sp  <= r_sp + fsp_pkg::STACK_CNT_W'(1);
                    r_mag <= w_quot;
                    if (w_quot == '0) begin
                        r_state <= r_neg ? S_SIGN : S_OUT;
                    end
                end

                S_SIGN: begin
                    // Sign goes on top so that it pops first
                    r_stk[r_sp[fsp_pkg::STACK_IDX_W-1:0]] <= fsp_pkg::CH_MINUS;
                    r_sp    <= r_sp + fsp_pkg::STACK_CNT_W'(1);
                    r_state <= S_OUT;
                end

                S_NULL: begin
                    // Push the text back to front
                    r_stk[r_sp[fsp_pkg::STACK_IDX_W-1:0]] <= fsp_pkg::null_char(r_ni);
                    r_sp <= r_sp + fsp_pkg::STACK_CNT_W'(1);
                    r_ni <= r_ni - fsp_pkg::NULL_IDX_W'(1);
                    if (r_ni == '0) begin
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    if (w_load_ok) begin
                        if (r_sp != '0) begin
                            r_ov   <= 1'b1;
                            r_byte <= r_stk[w_top[fsp_pkg::STACK_IDX_W-1:0]];
                            r_last <= (r_sp == fsp_pkg::STACK_CNT_W'(1)) && !r_fin;
                            r_ocnt <= w_cnt_inc;
                            r_done <= 1'b0;
                            r_cnt  <= w_cnt_inc;
                            r_sp   <= w_top;
                            if (r_sp == fsp_pkg::STACK_CNT_W'(1) && !r_fin) begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            // Completion beat carries the total, then clear the count
                            r_ov    <= 1'b1;
                            r_byte  <= '0;
                            r_last  <= 1'b1;
                            r_ocnt  <= r_cnt;
                            r_done  <= 1'b1;
                            r_cnt   <= '0;
                            r_fin   <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/fsp_digit.sv =====
// One digit step: split the magnitude into quotient and lowest digit.
module fsp_digit (
    input  logic [fsp_pkg::VALUE_W-1:0] i_mag,
    input  logic                        i_dec,
    output logic [fsp_pkg::VALUE_W-1:0] o_quot,
    output logic [3:0]                  o_digit
);

    logic [2*fsp_pkg::VALUE_W-1:0] w_prod;
    logic [fsp_pkg::VALUE_W-1:0]   w_q10;
    logic [fsp_pkg::VALUE_W-1:0]   w_back;
    logic [fsp_pkg::VALUE_W-1:0]   w_rem;

    assign w_prod = {{fsp_pkg::VALUE_W{1'b0}}, i_mag}
                  * {{fsp_pkg::VALUE_W{1'b0}}, fsp_pkg::RECIP_10};
    // Keep the product bits above the shift point; the quotient fits in 29 bits
    assign w_q10  = {{(fsp_pkg::RECIP_SHIFT-fsp_pkg::VALUE_W){1'b0}},
                     w_prod[2*fsp_pkg::VALUE_W-1:fsp_pkg::RECIP_SHIFT]};
    // q * 10 = q * 8 + q * 2
    assign w_back = {w_q10[fsp_pkg::VALUE_W-4:0], 3'b000}
                  + {w_q10[fsp_pkg::VALUE_W-2:0], 1'b0};
    assign w_rem  = i_mag - w_back;

    always_comb begin
        if (i_dec) begin
            o_quot  = w_q10;
            o_digit = w_rem[3:0];
        end else begin
            o_quot  = {4'b0000, i_mag[fsp_pkg::VALUE_W-1:4]};
            o_digit = i_mag[3:0];
        end
    end

endmodule

// ===== rtl/fsp_checker.sv =====
module fsp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [fsp_pkg::BYTE_W-1:0]    i_out_byte,
    input logic                          i_out_last,
    input logic [fsp_pkg::COUNT_W-1:0]   i_out_count,
    input logic                          i_out_done
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_last) && $stable(i_out_count) && $stable(i_out_done))
        else $error("output beat changed while stalled");

    // Completion beat is a zero byte closing its item
    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_last && i_out_byte == '0)
        else $error("malformed completion beat");

    // No new item while the current one still has characters to send
    a_busy_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready in the middle of an item");

    // A taken mid-item beat is followed at once by the next beat of the item
    a_next_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside an item");

    // A character beat after another in the same item counts up by one or saturates
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last ##1 i_out_valid && !i_out_done
            |-> i_out_count == $past(i_out_count) + fsp_pkg::COUNT_W'(1)
                || i_out_count == fsp_pkg::COUNT_MAX)
        else $error("character count did not advance");

endmodule

bind format_string_printer fsp_checker u_fsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.is_last),
    .i_out_count (o_out.char_count),
    .i_out_done  (o_out.done_res)
);
